### src/hufd_pkg.sv
// Shared types and constants for the Huffman tree-walk decoder.
package hufd_pkg;

  localparam int NODE_W = 7;
  localparam int SYM_W = 8;
  localparam int TREE_DEPTH = 1 << NODE_W;
  localparam int MAX_LEAVES = 64;
  localparam int OUT_DEPTH_DFLT = 4;

  localparam logic [NODE_W-1:0] ROOT_RST = 7'd3;
  localparam logic [NODE_W-1:0] LEAF_MIN = 7'd2;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic [NODE_W-1:0] right;
    logic [NODE_W-1:0] left;
  } node_t;

endpackage

### src/hufd_ofifo.sv
// Small register FIFO that holds decoded symbols until the output side takes them.
module hufd_ofifo import hufd_pkg::*; #(
  parameter int DEPTH = OUT_DEPTH_DFLT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [SYM_W-1:0] push_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // decoded_symbol[7:0]
  output logic [CNT_W-1:0] count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [SYM_W-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;

  assign pop = out_tvalid && out_tready;
  assign out_tvalid = (cnt_r != '0);
  assign out_tdata = slot_r[rd_ptr_r];
  assign count = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < CNT_W'(DEPTH))
    else $error("output FIFO overflow");
  a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("output FIFO count lost a push");
`endif

endmodule

### src/huffman_tree_bit_decoder_unit.sv
// Each decode item registers its next node in rd_q; a leaf's symbol is then pushed into the FIFO.
// Throughput: one load or decode item per cycle while in_tready is high; one tree read per bit.
// After a leaf_count write the root entry is fetched from the tree memory while input is blocked.
// Reset clears the walk to node 3 and leaf_count to 2; tree contents are undefined until loaded.
// The output FIFO holds results so a stalled consumer does not stop the walk at once.
module huffman_tree_bit_decoder_unit import hufd_pkg::*; #(
  parameter int OUT_DEPTH = OUT_DEPTH_DFLT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // node_index[6:0], left_child[13:7], right_child[20:14],
                                  // node_symbol[28:21], code_bit[29], zero[31:30]
  input  logic [0:0]  in_tuser,   // kind[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // decoded_symbol[7:0]
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data
);

  localparam int CNT_W = $clog2(OUT_DEPTH + 1);

  node_t            tree_mem [TREE_DEPTH];
  node_t            rd_q;
  logic [NODE_W-1:0] rd_addr;

  logic [NODE_W-1:0] root_r, cur_idx_r, pend_idx_r;
  node_t             root_ent_r, cur_ent_r;
  logic              pend_r, refresh_r;

  logic              in_acc, ld_acc, dec_acc;
  logic [NODE_W-1:0] ld_idx, next_idx, cur_idx_eff, cfg_root, lc;
  node_t             ld_ent, cur_ent_eff, cur_ent_nxt;
  logic              code_bit, rd_leaf, push;
  logic [CNT_W-1:0]  fifo_cnt;

  assign ld_idx = in_tdata[6:0];
  assign ld_ent.left = in_tdata[13:7];
  assign ld_ent.right = in_tdata[20:14];
  assign ld_ent.sym = in_tdata[28:21];
  assign code_bit = in_tdata[29];

  assign in_tready = !refresh_r &&
                     (({1'b0, fifo_cnt} + (CNT_W + 1)'(pend_r)) < (CNT_W + 1)'(OUT_DEPTH));
  assign in_acc = in_tvalid && in_tready;
  assign ld_acc = in_acc && (in_tuser[0] == KIND_LOAD);
  assign dec_acc = in_acc && (in_tuser[0] == KIND_DECODE);

  always_comb begin
    if (cfg_wr_data < LEAF_MIN) begin
      lc = LEAF_MIN;
    end else if (int'(cfg_wr_data) > MAX_LEAVES) begin
      lc = NODE_W'(MAX_LEAVES);
    end else begin
      lc = cfg_wr_data;
    end
    cfg_root = NODE_W'({1'b0, lc, 1'b0} - 9'd1);
  end

  assign rd_leaf = (rd_q.left == '0) && (rd_q.right == '0);
  assign push = pend_r && rd_leaf;

  always_comb begin
    if (pend_r) begin
      cur_ent_eff = rd_leaf ? root_ent_r : rd_q;
      cur_idx_eff = rd_leaf ? root_r : pend_idx_r;
    end else begin
      cur_ent_eff = cur_ent_r;
      cur_idx_eff = cur_idx_r;
    end
    next_idx = code_bit ? cur_ent_eff.right : cur_ent_eff.left;
    cur_ent_nxt = (ld_acc && (ld_idx == cur_idx_eff)) ? ld_ent : cur_ent_eff;
    rd_addr = cfg_wr_en ? cfg_root : next_idx;
  end

  always_ff @(posedge clk) begin
    if (ld_acc) begin
      tree_mem[ld_idx] <= ld_ent;
    end
    rd_q <= tree_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_r <= ROOT_RST;
      cur_idx_r <= ROOT_RST;
      pend_r <= 1'b0;
      refresh_r <= 1'b0;
    end else begin
      pend_r <= dec_acc;
      refresh_r <= cfg_wr_en;
      if (cfg_wr_en) begin
        root_r <= cfg_root;
        cur_idx_r <= cfg_root;
      end else if (refresh_r) begin
        cur_idx_r <= root_r;
      end else begin
        cur_idx_r <= cur_idx_eff;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dec_acc) begin
      pend_idx_r <= next_idx;
    end
    if (refresh_r) begin
      root_ent_r <= rd_q;
      cur_ent_r <= rd_q;
    end else begin
      if (ld_acc && (ld_idx == root_r)) begin
        root_ent_r <= ld_ent;
      end
      cur_ent_r <= cur_ent_nxt;
    end
  end

  hufd_ofifo #(
    .DEPTH(OUT_DEPTH),
    .CNT_W(CNT_W)
  ) u_ofifo (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_data(rd_q.sym),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .count(fifo_cnt)
  );

`ifndef SYNTHESIS
  a_room_for_pending: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> fifo_cnt < CNT_W'(OUT_DEPTH))
    else $error("pending decode has no room in the output FIFO");
  a_refresh_sets_root: assert property (@(posedge clk) disable iff (!rst_n)
    refresh_r |=> cur_idx_r == root_r)
    else $error("walk position not returned to root after leaf_count write");
  a_leaf_returns_root: assert property (@(posedge clk) disable iff (!rst_n)
    push && !ld_acc && !cfg_wr_en && !refresh_r |=> cur_idx_r == $past(root_r))
    else $error("walk did not return to root after a leaf");
  a_decode_reads: assert property (@(posedge clk) disable iff (!rst_n)
    dec_acc && !cfg_wr_en |=> pend_r && pend_idx_r == $past(next_idx))
    else $error("decode item did not issue its node read");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the Huffman tree-walk decoder with tree loads and code bits.
module testbench;
  import hufd_pkg::*;

  localparam int RAND_ITEMS = 1600;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SINK_HOLD = 300;
  localparam int DRAIN_MAX = 5000;
  localparam int SETTLE_CYCLES = 4;
  localparam int DIR_N = 18;
  localparam int EXTREME_N = 6;

  typedef struct {
    logic              kind;
    logic [NODE_W-1:0] idx;
    logic [NODE_W-1:0] lch;
    logic [NODE_W-1:0] rch;
    logic [SYM_W-1:0]  sym;
    logic              code_bit;
  } tree_item_t;

  typedef struct packed {
    logic              kind;
    logic [NODE_W-1:0] idx;
    logic [NODE_W-1:0] lch;
    logic [NODE_W-1:0] rch;
    logic [SYM_W-1:0]  sym;
    logic              code_bit;
    logic              typed;
    logic              yields;
    logic [SYM_W-1:0]  exp_sym;
  } dir_row_t;

  // Rows run from reset, where the root is node 3.
  localparam dir_row_t DIR_TAB [DIR_N] = '{
    '{KIND_LOAD,   7'd3,   7'd1,   7'd2,   8'hAA, 1'b0, 1'b1, 1'b0, 8'h00},
    '{KIND_LOAD,   7'd1,   7'd0,   7'd0,   8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
    '{KIND_LOAD,   7'd2,   7'd0,   7'd0,   8'hFF, 1'b0, 1'b1, 1'b0, 8'h00},
    '{KIND_DECODE, 7'd127, 7'd127, 7'd127, 8'hFF, 1'b0, 1'b1, 1'b1, 8'h00},
    '{KIND_DECODE, 7'd0,   7'd0,   7'd0,   8'h00, 1'b1, 1'b1, 1'b1, 8'hFF},
    '{KIND_LOAD,   7'd0,   7'd0,   7'd0,   8'h5A, 1'b0, 1'b1, 1'b0, 8'h00},
    '{KIND_LOAD,   7'd3,   7'd0,   7'd2,   8'h11, 1'b0, 1'b1, 1'b0, 8'h00},
    '{KIND_DECODE, 7'd85,  7'd42,  7'd85,  8'h55, 1'b0, 1'b1, 1'b1, 8'h5A},
    '{KIND_LOAD,   7'd3,   7'd1,   7'd2,   8'h11, 1'b1, 1'b1, 1'b0, 8'h00},
    '{KIND_LOAD,   7'd1,   7'd2,   7'd0,   8'h22, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_DECODE, 7'd42,  7'd85,  7'd42,  8'hAA, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_LOAD,   7'd1,   7'd0,   7'd2,   8'h33, 1'b1, 1'b0, 1'b0, 8'h00},
    '{KIND_DECODE, 7'd0,   7'd0,   7'd0,   8'h00, 1'b1, 1'b0, 1'b0, 8'h00},
    '{KIND_DECODE, 7'd127, 7'd127, 7'd127, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_DECODE, 7'd0,   7'd0,   7'd0,   8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
    '{KIND_LOAD,   7'd127, 7'd127, 7'd127, 8'hFF, 1'b1, 1'b1, 1'b0, 8'h00},
    '{KIND_LOAD,   7'd64,  7'd0,   7'd127, 8'h80, 1'b0, 1'b1, 1'b0, 8'h00},
    '{KIND_DECODE, 7'd1,   7'd2,   7'd3,   8'h01, 1'b1, 1'b1, 1'b1, 8'hFF}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;

  logic [NODE_W-1:0] left_of [TREE_DEPTH];
  logic [NODE_W-1:0] right_of [TREE_DEPTH];
  logic [SYM_W-1:0]  sym_of [TREE_DEPTH];
  bit                loaded [TREE_DEPTH];
  logic [NODE_W-1:0] walk_pos;
  logic [NODE_W-1:0] leaf_cnt;

  logic [SYM_W-1:0] pending_symbols [$];
  int  errors = 0;
  int  cycle_cnt = 0;
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;

  huffman_tree_bit_decoder_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] leaves);
    return NODE_W'((2 * leaves) - 1);
  endfunction

  function automatic logic [NODE_W-1:0] clamp_leaves(input logic [6:0] raw);
    if (raw < LEAF_MIN) return LEAF_MIN;
    if (int'(raw) > MAX_LEAVES) return NODE_W'(MAX_LEAVES);
    return raw;
  endfunction

  // Applies one accepted item to the tree copy and, if queue_symbol is set, queues the symbol of any leaf reached.
  function automatic void tree_walk_step(input tree_item_t it, input bit queue_symbol);
    logic [NODE_W-1:0] nxt;
    if (it.kind == KIND_LOAD) begin
      left_of[it.idx] = it.lch;
      right_of[it.idx] = it.rch;
      sym_of[it.idx] = it.sym;
      loaded[it.idx] = 1'b1;
    end else begin
      nxt = it.code_bit ? right_of[walk_pos] : left_of[walk_pos];
      if (left_of[nxt] == '0 && right_of[nxt] == '0) begin
        if (queue_symbol) pending_symbols.push_back(sym_of[nxt]);
        walk_pos = root_of(leaf_cnt);
      end else begin
        walk_pos = nxt;
      end
    end
  endfunction

  function automatic bit step_safe(input logic cb);
    return loaded[walk_pos] && loaded[cb ? right_of[walk_pos] : left_of[walk_pos]];
  endfunction

  function automatic tree_item_t load_item(input logic [NODE_W-1:0] idx,
                                           input logic [NODE_W-1:0] lch,
                                           input logic [NODE_W-1:0] rch,
                                           input logic [SYM_W-1:0] sym);
    tree_item_t it;
    it.kind = KIND_LOAD;
    it.idx = idx;
    it.lch = lch;
    it.rch = rch;
    it.sym = sym;
    it.code_bit = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int src_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 65) return 0;
    return gap_len();
  endfunction

  // Called at a falling edge; returns at a falling edge after the item is taken.
  task automatic send_item(input tree_item_t it, input bit typed, input bit yields,
                           input logic [SYM_W-1:0] exp_sym);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, it.code_bit, it.sym, it.rch, it.lch, it.idx};
    in_tuser <= it.kind;
    do @(posedge clk); while (!in_tready);
    tree_walk_step(it, !typed);
    if (typed && yields) pending_symbols.push_back(exp_sym);
    @(negedge clk);
    gap = src_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_decode();
    tree_item_t it;
    logic cb;
    logic [NODE_W-1:0] tgt;
    cb = 1'($urandom_range(0, 1));
    if (!step_safe(cb)) cb = ~cb;
    if (step_safe(cb)) begin
      it.kind = KIND_DECODE;
      it.idx = NODE_W'($urandom_range(0, 127));
      it.lch = NODE_W'($urandom_range(0, 127));
      it.rch = NODE_W'($urandom_range(0, 127));
      it.sym = SYM_W'($urandom_range(0, 255));
      it.code_bit = cb;
    end else begin
      tgt = !loaded[walk_pos] ? walk_pos : (cb ? right_of[walk_pos] : left_of[walk_pos]);
      it = load_item(tgt, '0, '0, SYM_W'($urandom_range(0, 255)));
    end
    send_item(it, 1'b0, 1'b0, '0);
  endtask

  task automatic write_leaf_count(input logic [6:0] raw);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_symbols.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= raw;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    leaf_cnt = clamp_leaves(raw);
    walk_pos = root_of(leaf_cnt);
  endtask

  // Builds a random full tree for the current leaf count and loads it in random order.
  task automatic load_tree(output int n_sent);
    int ids [$];
    int pool [$];
    tree_item_t nodes [$];
    tree_item_t t_item;
    int n_ids, j, tmp, a, b, nid;
    n_ids = 2 * leaf_cnt - 2;
    for (int i = 1; i <= n_ids; i++) ids.push_back(i);
    for (int i = n_ids - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    for (int i = 0; i < leaf_cnt; i++) begin
      nodes.push_back(load_item(NODE_W'(ids[i]), '0, '0, SYM_W'($urandom_range(0, 255))));
      pool.push_back(ids[i]);
    end
    for (int k = 0; k < leaf_cnt - 1; k++) begin
      nid = (k == leaf_cnt - 2) ? int'(root_of(leaf_cnt)) : ids[leaf_cnt + k];
      j = $urandom_range(0, pool.size() - 1);
      a = pool[j];
      pool.delete(j);
      j = $urandom_range(0, pool.size() - 1);
      b = pool[j];
      pool.delete(j);
      nodes.push_back(load_item(NODE_W'(nid), NODE_W'(a), NODE_W'(b),
                                SYM_W'($urandom_range(0, 255))));
      pool.push_back(nid);
    end
    for (int i = nodes.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t_item = nodes[i];
      nodes[i] = nodes[j];
      nodes[j] = t_item;
    end
    foreach (nodes[i]) send_item(nodes[i], 1'b0, 1'b0, '0);
    n_sent = nodes.size();
  endtask

  function automatic logic [6:0] pick_raw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 7'($urandom_range(2, 12));
    if (r < 93) return 7'($urandom_range(13, 64));
    return 7'($urandom_range(0, 127));
  endfunction

  initial begin : sink
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (SINK_HOLD - 1) @(negedge clk);
      end else begin
        if (stall == 0 && idle_on && $urandom_range(0, 99) < 20) stall = gap_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          stall--;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [SYM_W-1:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_symbols.size() == 0) begin
        $error("decoded_symbol: expected none, got %02h", out_tdata);
        errors++;
      end else begin
        want = pending_symbols.pop_front();
        if (out_tdata !== want) begin
          $error("decoded_symbol: expected %02h, got %02h", want, out_tdata);
          errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [6:0] extreme_raw [EXTREME_N];
    logic [6:0] raw;
    tree_item_t it;
    dir_row_t row;
    int rand_items, phase, n_dec, n_tree, n;
    extreme_raw = '{7'd0, 7'd127, 7'd64, 7'd1, 7'd65, 7'd2};
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    for (int i = 0; i < TREE_DEPTH; i++) begin
      left_of[i] = '0;
      right_of[i] = '0;
      sym_of[i] = '0;
      loaded[i] = 1'b0;
    end
    leaf_cnt = LEAF_MIN;
    walk_pos = ROOT_RST;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      row = DIR_TAB[i];
      it.kind = row.kind;
      it.idx = row.idx;
      it.lch = row.lch;
      it.rch = row.rch;
      it.sym = row.sym;
      it.code_bit = row.code_bit;
      send_item(it, row.typed, row.yields, row.exp_sym);
    end

    // The sink stops for a long stretch while decode items, or the loads they need, keep coming back to back.
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_decode();

    rand_items = 0;
    phase = 0;
    while (rand_items < RAND_ITEMS) begin
      idle_on = (phase % 4 != 1);
      raw = (phase < EXTREME_N) ? extreme_raw[phase] : pick_raw();
      if (phase > 0 && clamp_leaves(raw) == leaf_cnt && $urandom_range(0, 2) == 0) begin
        write_leaf_count(raw);
      end else begin
        write_leaf_count(raw);
        load_tree(n_tree);
        rand_items += n_tree;
      end
      n_dec = $urandom_range(40, 120);
      for (int i = 0; i < n_dec; i++) begin
        if ($urandom_range(0, 99) < 6) begin
          send_item(load_item(NODE_W'($urandom_range(0, 127)),
                              NODE_W'($urandom_range(0, 127)),
                              NODE_W'($urandom_range(0, 127)),
                              SYM_W'($urandom_range(0, 255))),
                    1'b0, 1'b0, '0);
        end else begin
          send_decode();
        end
      end
      rand_items += n_dec;
      phase++;
    end

    in_tvalid <= 1'b0;
    n = 0;
    while (n < DRAIN_MAX && pending_symbols.size() != 0) begin
      @(negedge clk);
      n++;
    end
    repeat (20) @(negedge clk);
    if (pending_symbols.size() != 0) begin
      $error("decoded_symbol: %0d expected items never arrived", pending_symbols.size());
      errors++;
    end
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
